[sv/hds_pkg.sv]
// Shared types, constants and register codes of the heat diffusion stencil block.
`default_nettype none

package hds_pkg;

  localparam int VAL_W   = 16;
  localparam int COEF_W  = 16;
  localparam int COLS_W  = 6;
  localparam int ROWS_W  = 11;
  localparam int DIFF_W  = 19;
  localparam int PROD_W  = COEF_W + 1 + DIFF_W;
  localparam int FRAC_W  = 16;
  localparam int TERM_W  = PROD_W - FRAC_W;
  localparam int SUM_W   = TERM_W + 2;

  localparam int MAX_COLS_DEF = 63;
  localparam int MAX_ROWS     = 1024;
  localparam int MIN_COLS     = 3;
  localparam int MIN_ROWS     = 2;

  localparam logic [VAL_W-1:0]  ONE_Q15       = 16'd32768;
  localparam logic [COLS_W-1:0] GRID_COLS_RST = 6'd32;
  localparam logic [ROWS_W-1:0] GRID_ROWS_RST = 11'd32;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Y    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd3;

  typedef struct packed {
    logic              take_in;
    logic              rd_en;
    logic [COLS_W-1:0] addr;
    logic [COLS_W-1:0] addr_right;
    logic              use_left;
    logic              use_right;
    logic              flush;
    logic              mul_x;
    logic              mul_y;
    logic              sum;
    logic              emit;
    logic              run_last;
    logic              frame_last;
    logic              wr_en;
    logic              zero_top;
  } hds_cmd_t;

  typedef struct packed {
    logic out_free;
  } hds_sts_t;

endpackage

`default_nettype wire

[sv/hds_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 63
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[sv/hds_ctrl.sv]
// Controller: grid position counters and the per-cell / flush sequencer.
`default_nettype none

module hds_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [hds_pkg::COLS_W-1:0] cols_used,
  input  wire logic [hds_pkg::ROWS_W-1:0] rows_used,
  input  wire logic                      size_wr,
  input  wire hds_pkg::hds_sts_t         sts,
  output hds_pkg::hds_cmd_t              cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WR0  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_MULX = 3'd3;
  localparam logic [2:0] S_MULY = 3'd4;
  localparam logic [2:0] S_SUM  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]                 state_r, state_nxt;
  logic [hds_pkg::COLS_W-1:0] col_r, col_nxt;
  logic [hds_pkg::ROWS_W-1:0] row_r, row_nxt;
  logic [hds_pkg::COLS_W-1:0] idx_r, idx_nxt;
  logic                       last_r, last_nxt;
  logic                       flush_r, flush_nxt;

  logic [hds_pkg::COLS_W-1:0] cur_c, sel_c;
  logic [hds_pkg::ROWS_W-1:0] cur_r;
  logic                       cur_last, right_ok, is_end, accept;
  logic [hds_pkg::COLS_W:0]   c_inc;
  logic [hds_pkg::ROWS_W:0]   r_inc;

  assign cur_c    = (col_r >= cols_used) ? '0 : col_r;
  assign cur_r    = (row_r >= rows_used) ? '0 : row_r;
  assign cur_last = (cur_r == rows_used - 1'b1) && (cur_c == cols_used - 1'b1);
  assign c_inc    = {1'b0, cur_c} + 1'b1;
  assign r_inc    = {1'b0, cur_r} + 1'b1;

  assign sel_c    = (state_r == S_IDLE) ? cur_c : idx_r;
  assign right_ok = ({1'b0, sel_c} + 1'b1) < {1'b0, cols_used};
  assign is_end   = (idx_r == cols_used - 1'b1);

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    idx_nxt   = idx_r;
    last_nxt  = last_r;
    flush_nxt = flush_r;

    cmd            = '0;
    cmd.addr       = sel_c;
    cmd.addr_right = right_ok ? sel_c + 1'b1 : sel_c;
    cmd.use_left   = (idx_r != '0);
    cmd.use_right  = right_ok;
    cmd.flush      = flush_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.take_in = 1'b1;
          cmd.rd_en   = 1'b1;
          idx_nxt     = cur_c;
          last_nxt    = cur_last;
          // advance the raster position now; the item is fully in hand
          if (c_inc >= {1'b0, cols_used}) begin
            col_nxt = '0;
            row_nxt = (r_inc >= {1'b0, rows_used}) ? '0 : r_inc[hds_pkg::ROWS_W-1:0];
          end else begin
            col_nxt = c_inc[hds_pkg::COLS_W-1:0];
            row_nxt = cur_r;
          end
          state_nxt = (cur_r == '0) ? S_WR0 : S_MULX;
        end
      end
      S_WR0: begin
        cmd.wr_en    = 1'b1;
        cmd.zero_top = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_MULX;
      end
      S_MULX: begin
        cmd.mul_x = 1'b1;
        state_nxt = S_MULY;
      end
      S_MULY: begin
        cmd.mul_y = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (flush_r) begin
            cmd.run_last   = is_end;
            cmd.frame_last = is_end;
            if (is_end) begin
              flush_nxt = 1'b0;
              state_nxt = S_IDLE;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = S_RD;
            end
          end else begin
            cmd.wr_en    = 1'b1;
            cmd.run_last = !last_r;
            if (last_r) begin
              // frame done: sweep the final row out
              flush_nxt = 1'b1;
              idx_nxt   = '0;
              state_nxt = S_RD;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (size_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      idx_r   <= '0;
      last_r  <= 1'b0;
      flush_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      idx_r   <= idx_nxt;
      last_r  <= last_nxt;
      flush_r <= flush_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/hds_dp.sv]
// Datapath: line stores, stencil differences, shared multiplier, saturation, output register.
`default_nettype none

module hds_dp #(
  parameter int MAX_COLS = hds_pkg::MAX_COLS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire hds_pkg::hds_cmd_t          cmd,
  output hds_pkg::hds_sts_t               sts,
  input  wire logic [hds_pkg::VAL_W-1:0]  in_data,
  input  wire logic [hds_pkg::COEF_W-1:0] coef_x,
  input  wire logic [hds_pkg::COEF_W-1:0] coef_y,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [hds_pkg::VAL_W-1:0]       out_data,
  output logic                            out_run_last,
  output logic                            out_frame_last
);

  localparam int AW = $clog2(MAX_COLS);

  logic [hds_pkg::VAL_W-1:0] v_r, hold_r, res_r;
  logic [hds_pkg::VAL_W-1:0] mid_q, right_q, top_q;
  logic [hds_pkg::VAL_W-1:0] left_v, right_v, dn_v, top_wdata;

  logic [hds_pkg::DIFF_W-1:0]        dx, dy;
  logic signed [hds_pkg::COEF_W:0]   mul_a;
  logic signed [hds_pkg::DIFF_W-1:0] mul_b;
  logic signed [hds_pkg::PROD_W-1:0] prod_nxt, prod_r;
  logic signed [hds_pkg::TERM_W-1:0] px_r, py;
  logic signed [hds_pkg::SUM_W-1:0]  sum;
  logic [hds_pkg::VAL_W-1:0]         sat;

  logic out_valid_r, out_run_last_r, out_frame_last_r;
  logic [hds_pkg::VAL_W-1:0] out_data_r;

  assign top_wdata = cmd.zero_top ? '0 : mid_q;

  // row above the output row
  hds_ram #(.WIDTH(hds_pkg::VAL_W), .DEPTH(MAX_COLS)) u_top (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (cmd.addr[AW-1:0]),
    .wr_data (top_wdata),
    .rd_en   (cmd.rd_en),
    .rd_addr (cmd.addr[AW-1:0]),
    .rd_data (top_q)
  );

  // output row, center tap
  hds_ram #(.WIDTH(hds_pkg::VAL_W), .DEPTH(MAX_COLS)) u_mid_c (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (cmd.addr[AW-1:0]),
    .wr_data (v_r),
    .rd_en   (cmd.rd_en),
    .rd_addr (cmd.addr[AW-1:0]),
    .rd_data (mid_q)
  );

  // output row, right tap (mirror copy)
  hds_ram #(.WIDTH(hds_pkg::VAL_W), .DEPTH(MAX_COLS)) u_mid_r (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (cmd.addr[AW-1:0]),
    .wr_data (v_r),
    .rd_en   (cmd.rd_en),
    .rd_addr (cmd.addr_right[AW-1:0]),
    .rd_data (right_q)
  );

  assign left_v  = cmd.use_left  ? hold_r  : '0;
  assign right_v = cmd.use_right ? right_q : '0;
  assign dn_v    = cmd.flush     ? '0      : v_r;

  assign dx = {3'b000, left_v} + {3'b000, right_v} - {2'b00, mid_q, 1'b0};
  assign dy = {3'b000, top_q}  + {3'b000, dn_v}    - {2'b00, mid_q, 1'b0};

  assign mul_a    = $signed({1'b0, (cmd.mul_y ? coef_y : coef_x)});
  assign mul_b    = $signed(cmd.mul_y ? dy : dx);
  assign prod_nxt = mul_a * mul_b;

  // arithmetic shift by the fraction width floors toward minus infinity
  assign py  = prod_r[hds_pkg::PROD_W-1:hds_pkg::FRAC_W];
  assign sum = $signed({{(hds_pkg::SUM_W-hds_pkg::VAL_W){1'b0}}, mid_q})
             + $signed({{2{px_r[hds_pkg::TERM_W-1]}}, px_r})
             + $signed({{2{py[hds_pkg::TERM_W-1]}}, py});

  always_comb begin
    if (sum[hds_pkg::SUM_W-1]) begin
      sat = '0;
    end else if (sum > $signed({{(hds_pkg::SUM_W-hds_pkg::VAL_W){1'b0}}, hds_pkg::ONE_Q15})) begin
      sat = hds_pkg::ONE_Q15;
    end else begin
      sat = sum[hds_pkg::VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      v_r <= in_data;
    end
    if (cmd.mul_x || cmd.mul_y) begin
      prod_r <= prod_nxt;
    end
    if (cmd.mul_y) begin
      px_r <= prod_r[hds_pkg::PROD_W-1:hds_pkg::FRAC_W];
    end
    if (cmd.sum) begin
      res_r <= sat;
    end
    if (cmd.emit) begin
      hold_r           <= mid_q;
      out_data_r       <= res_r;
      out_run_last_r   <= cmd.run_last;
      out_frame_last_r <= cmd.frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.out_free   = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;
  assign out_run_last   = out_run_last_r;
  assign out_frame_last = out_frame_last_r;

endmodule

`default_nettype wire

[sv/heat_diffusion_stencil_step_top.sv]
// Top level of the heat diffusion stencil step: configuration registers, controller, datapath.
//
// Usage: cells of one grid stream in on in_* in raster order, one per
// transaction. Each cell from the second row on yields the updated value of
// the cell one row above, same column, on out_*; the frame's last cell also
// yields the whole final row. out_tlast marks the last result of an input
// transaction, out_tuser marks the result for the frame's final cell.
// cfg_* writes coef_x, coef_y, grid_cols, grid_rows (index 0..3); a write to
// either size register restarts the frame position. Write it only while idle.
// Sequence: a first-row cell passes states IDLE and WR0, any other cell IDLE,
// MULX, MULY, SUM and EMIT; the end-of-frame sweep runs RD, MULX, MULY, SUM
// and EMIT per column. This comes from the one shared multiplier that forms
// both product terms in turn, plus the registered line-store read; a new cell is taken only in IDLE.
// Output: the result passes prod_r, px_r and res_r; out_tvalid rises as EMIT loads it.
// Reset: coefficients 0, grid 32 x 32, position at the top left; the line
// stores need no clearing since the first row writes them before any read data is used.
// A stalled receiver holds the output register; the block takes the next
// cell meanwhile and stalls only when another result is ready to load.
`default_nettype none

module heat_diffusion_stencil_step_top #(
  parameter int MAX_COLS = hds_pkg::MAX_COLS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [15:0]                   in_tdata,   // [15:0] cell_value
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [15:0]                        out_tdata,  // [15:0] new_value
  output logic                               out_tlast,  // run_last
  output logic                               out_tuser,  // [0] frame_last
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [hds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                   cfg_data
);

  logic [hds_pkg::COEF_W-1:0] coef_x_r, coef_y_r;
  logic [hds_pkg::COLS_W-1:0] grid_cols_r, cols_used;
  logic [hds_pkg::ROWS_W-1:0] grid_rows_r, rows_used;
  logic                       cfg_wr, size_wr;
  hds_pkg::hds_cmd_t          cmd;
  hds_pkg::hds_sts_t          sts;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign size_wr   = cfg_wr && ((cfg_index == hds_pkg::REG_GRID_COLS) ||
                                (cfg_index == hds_pkg::REG_GRID_ROWS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_x_r    <= '0;
      coef_y_r    <= '0;
      grid_cols_r <= hds_pkg::GRID_COLS_RST;
      grid_rows_r <= hds_pkg::GRID_ROWS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        hds_pkg::REG_COEF_X:    coef_x_r    <= cfg_data;
        hds_pkg::REG_COEF_Y:    coef_y_r    <= cfg_data;
        hds_pkg::REG_GRID_COLS: grid_cols_r <= cfg_data[hds_pkg::COLS_W-1:0];
        hds_pkg::REG_GRID_ROWS: grid_rows_r <= cfg_data[hds_pkg::ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the grid size to what the line stores and the frame logic support
  always_comb begin
    if (grid_cols_r < hds_pkg::COLS_W'(hds_pkg::MIN_COLS)) begin
      cols_used = hds_pkg::COLS_W'(hds_pkg::MIN_COLS);
    end else if (grid_cols_r > hds_pkg::COLS_W'(MAX_COLS)) begin
      cols_used = hds_pkg::COLS_W'(MAX_COLS);
    end else begin
      cols_used = grid_cols_r;
    end
    if (grid_rows_r < hds_pkg::ROWS_W'(hds_pkg::MIN_ROWS)) begin
      rows_used = hds_pkg::ROWS_W'(hds_pkg::MIN_ROWS);
    end else if (grid_rows_r > hds_pkg::ROWS_W'(hds_pkg::MAX_ROWS)) begin
      rows_used = hds_pkg::ROWS_W'(hds_pkg::MAX_ROWS);
    end else begin
      rows_used = grid_rows_r;
    end
  end

  hds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .cols_used (cols_used),
    .rows_used (rows_used),
    .size_wr   (size_wr),
    .sts       (sts),
    .cmd       (cmd)
  );

  hds_dp #(.MAX_COLS(MAX_COLS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_data        (in_tdata),
    .coef_x         (coef_x_r),
    .coef_y         (coef_y_r),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_data       (out_tdata),
    .out_run_last   (out_tlast),
    .out_frame_last (out_tuser)
  );

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction accepted while a cell is in flight");

  a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("frame end result not marked as last of its run");

  a_cols_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cols_used >= hds_pkg::COLS_W'(hds_pkg::MIN_COLS)) &&
    (cols_used <= hds_pkg::COLS_W'(MAX_COLS)))
    else $error("column count outside the line store");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result loaded over an untaken result");

endmodule

`default_nettype wire
